[rtl/lrast_pkg.sv]
// Shared types and constants for the lazy range add / range sum block.
package lrast_pkg;

  localparam int unsigned INDEX_WIDTH = 11;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned OUT_WIDTH   = 64;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_SUM = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_AMUL_LO,
    S_AMUL_HI,
    S_AMUL_CAP,
    S_READ,
    S_UPDATE,
    S_QMUL,
    S_QSUB
  } state_t;

endpackage

[rtl/lrast_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lrast_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 1025
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/lrast_mul.sv]
// Shared multiplier: wrapping product of a sum-width word and an index, registered.
module lrast_mul #(
  parameter int SW = 64,
  parameter int BW = 12
) (
  input  logic          clk,
  input  logic [SW-1:0] mul_a,
  input  logic [BW-1:0] mul_b,
  output logic [SW-1:0] prod_r
);

  logic [SW+BW-1:0] full;

  assign full = {{BW{1'b0}}, mul_a} * {{SW{1'b0}}, mul_b};

  always_ff @(posedge clk) begin
    prod_r <= full[SW-1:0];
  end

endmodule

[rtl/lazy_range_add_sum_tree.sv]
// Top level: range add / range sum store with sequencer, shared multiplier and RAM.
//
// Range add and range sum over elements 1..elements_in_use. The store is kept as
// two interleaved prefix-sum (binary indexed) trees in one RAM word per index, so
// every range sum equals the lazily propagated segment tree sum, wrapping at
// SUM_WIDTH bits and sign-extended to 64 bits. A transaction is accepted when
// start is high and busy is low; busy then stays high until the result strobe,
// except for a bad range, which never raises busy. Each tree step is a
// read-modify-write on the RAM port, through S_READ and S_UPDATE, and every walk
// ends with one more pass through S_READ to see that it is done. An add first
// runs the multiplier through S_AMUL_LO, S_AMUL_HI and S_AMUL_CAP, then two walks
// of up to log2(MAX_ELEMENTS)+1 steps each. A sum runs two walks of up to
// log2(MAX_ELEMENTS) steps, each followed by the multiplier in S_QMUL and S_QSUB.
// The result strobe comes in the same cycle as busy drops. A bad range returns its
// error strobe in the cycle after acceptance. After reset and after every write to
// elements_in_use every RAM entry is cleared, one entry a cycle, with busy high.
// The result strobe out_valid lasts one cycle and cannot be stalled; cfg_ready is
// always high.
module lazy_range_add_sum_tree #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int SUM_WIDTH    = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_command,
  input  logic [lrast_pkg::INDEX_WIDTH-1:0]   in_range_low,
  input  logic [lrast_pkg::INDEX_WIDTH-1:0]   in_range_high,
  input  logic signed [lrast_pkg::VALUE_WIDTH-1:0] in_add_value,
  output logic                                out_valid,
  output logic signed [lrast_pkg::OUT_WIDTH-1:0] out_range_sum,
  output logic                                out_range_error,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lrast_pkg::INDEX_WIDTH-1:0]   cfg_data
);

  localparam int DEPTH = MAX_ELEMENTS + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = AW + 1;
  localparam int SW    = SUM_WIDTH;

  lrast_pkg::state_t state_r, state_nxt;

  logic [AW-1:0] elem_r, elem_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          phase_r, phase_nxt;
  logic          cmd_r, cmd_nxt;
  logic [lrast_pkg::INDEX_WIDTH-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [SW-1:0] val_r, val_nxt;
  logic [SW-1:0] d2lo_r, d2lo_nxt, d2hi_r, d2hi_nxt;
  logic [SW-1:0] acc1_r, acc1_nxt, acc2_r, acc2_nxt;
  logic [SW-1:0] res_r, res_nxt;
  logic [SW-1:0] out_sum_r, out_sum_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_err_r, out_err_nxt;

  logic [SW-1:0]   mul_a, prod;
  logic [PW-1:0]   mul_b;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [2*SW-1:0] ram_wdata, ram_rdata;
  logic [SW-1:0]   rd1, rd2, d1, d2, prefix;
  logic [PW-1:0]   lowbit;
  logic            accept, bad_range, walk_end;

  assign busy      = (state_r != lrast_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign bad_range = (in_range_low == '0) || (in_range_low > in_range_high) ||
                     (in_range_high > elem_r);

  assign rd1    = ram_rdata[SW-1:0];
  assign rd2    = ram_rdata[2*SW-1:SW];
  // Second add walk carries the negated deltas at range_high+1.
  assign d1     = phase_r ? (SW'(0) - val_r) : val_r;
  assign d2     = phase_r ? (SW'(0) - d2hi_r) : d2lo_r;
  assign lowbit = pos_r & (~pos_r + PW'(1));
  assign prefix = prod - acc2_r;
  assign walk_end = (cmd_r == lrast_pkg::CMD_ADD) ? (pos_r > PW'(MAX_ELEMENTS))
                                                  : (pos_r == '0);

  lrast_mul #(.SW(SW), .BW(PW)) u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod_r(prod)
  );

  lrast_ram #(.WIDTH(2*SW), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(pos_r[AW-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrast_pkg::S_CLEAR;
      elem_r      <= AW'(MAX_ELEMENTS);
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      elem_r      <= elem_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    phase_r   <= phase_nxt;
    cmd_r     <= cmd_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    val_r     <= val_nxt;
    d2lo_r    <= d2lo_nxt;
    d2hi_r    <= d2hi_nxt;
    acc1_r    <= acc1_nxt;
    acc2_r    <= acc2_nxt;
    res_r     <= res_nxt;
    out_sum_r <= out_sum_nxt;
    out_err_r <= out_err_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    elem_nxt      = elem_r;
    clr_nxt       = clr_r;
    pos_nxt       = pos_r;
    phase_nxt     = phase_r;
    cmd_nxt       = cmd_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    val_nxt       = val_r;
    d2lo_nxt      = d2lo_r;
    d2hi_nxt      = d2hi_r;
    acc1_nxt      = acc1_r;
    acc2_nxt      = acc2_r;
    res_nxt       = res_r;
    out_sum_nxt   = out_sum_r;
    out_err_nxt   = out_err_r;
    out_valid_nxt = 1'b0;
    mul_a         = val_r;
    mul_b         = PW'(lo_r - lrast_pkg::INDEX_WIDTH'(1));
    ram_we        = 1'b0;
    ram_waddr     = pos_r[AW-1:0];
    ram_wdata     = {rd2 + d2, rd1 + d1};

    unique case (state_r)
      lrast_pkg::S_CLEAR: begin
        // Zero one entry a cycle.
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(MAX_ELEMENTS)) begin
          state_nxt = lrast_pkg::S_IDLE;
        end
      end
      lrast_pkg::S_IDLE: begin
        if (accept) begin
          cmd_nxt  = in_command;
          lo_nxt   = in_range_low;
          hi_nxt   = in_range_high;
          val_nxt  = SW'(in_add_value);
          phase_nxt = 1'b0;
          acc1_nxt = '0;
          acc2_nxt = '0;
          pos_nxt  = PW'(in_range_high);
          if (bad_range) begin
            // Drop the transaction, report the error next cycle.
            out_valid_nxt = 1'b1;
            out_err_nxt   = 1'b1;
            out_sum_nxt   = '0;
          end else if (in_command == lrast_pkg::CMD_ADD) begin
            state_nxt = lrast_pkg::S_AMUL_LO;
          end else begin
            state_nxt = lrast_pkg::S_READ;
          end
        end
      end
      lrast_pkg::S_AMUL_LO: begin
        mul_b     = PW'(lo_r - lrast_pkg::INDEX_WIDTH'(1));
        state_nxt = lrast_pkg::S_AMUL_HI;
      end
      lrast_pkg::S_AMUL_HI: begin
        d2lo_nxt  = prod;
        mul_b     = PW'(hi_r);
        state_nxt = lrast_pkg::S_AMUL_CAP;
      end
      lrast_pkg::S_AMUL_CAP: begin
        d2hi_nxt  = prod;
        pos_nxt   = PW'(lo_r);
        state_nxt = lrast_pkg::S_READ;
      end
      lrast_pkg::S_READ: begin
        if (walk_end) begin
          if (cmd_r == lrast_pkg::CMD_SUM) begin
            state_nxt = lrast_pkg::S_QMUL;
          end else if (!phase_r) begin
            phase_nxt = 1'b1;
            pos_nxt   = PW'(hi_r) + PW'(1);
          end else begin
            out_valid_nxt = 1'b1;
            out_err_nxt   = 1'b0;
            out_sum_nxt   = '0;
            state_nxt     = lrast_pkg::S_IDLE;
          end
        end else begin
          state_nxt = lrast_pkg::S_UPDATE;
        end
      end
      lrast_pkg::S_UPDATE: begin
        if (cmd_r == lrast_pkg::CMD_ADD) begin
          ram_we  = 1'b1;
          pos_nxt = pos_r + lowbit;
        end else begin
          acc1_nxt = acc1_r + rd1;
          acc2_nxt = acc2_r + rd2;
          pos_nxt  = pos_r - lowbit;
        end
        state_nxt = lrast_pkg::S_READ;
      end
      lrast_pkg::S_QMUL: begin
        mul_a     = acc1_r;
        mul_b     = phase_r ? PW'(lo_r - lrast_pkg::INDEX_WIDTH'(1)) : PW'(hi_r);
        state_nxt = lrast_pkg::S_QSUB;
      end
      lrast_pkg::S_QSUB: begin
        if (!phase_r) begin
          // Hold prefix(high), advance to prefix(low-1).
          res_nxt   = prefix;
          phase_nxt = 1'b1;
          acc1_nxt  = '0;
          acc2_nxt  = '0;
          pos_nxt   = PW'(lo_r - lrast_pkg::INDEX_WIDTH'(1));
          state_nxt = lrast_pkg::S_READ;
        end else begin
          out_valid_nxt = 1'b1;
          out_err_nxt   = 1'b0;
          out_sum_nxt   = res_r - prefix;
          state_nxt     = lrast_pkg::S_IDLE;
        end
      end
      default: state_nxt = lrast_pkg::S_IDLE;
    endcase

    // A register write restarts the clearing pass.
    if (cfg_valid && cfg_ready) begin
      if (cfg_data == '0) begin
        elem_nxt = AW'(1);
      end else if (int'(cfg_data) > MAX_ELEMENTS) begin
        elem_nxt = AW'(MAX_ELEMENTS);
      end else begin
        elem_nxt = AW'(cfg_data);
      end
      clr_nxt   = '0;
      state_nxt = lrast_pkg::S_CLEAR;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_range_error = out_err_r;
  assign out_range_sum   = lrast_pkg::OUT_WIDTH'($signed(out_sum_r));

  a_result_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy || start))
    else $error("result strobe without a transaction");

  a_error_zero_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_error) |-> (out_range_sum == '0))
    else $error("error result with nonzero sum");

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> busy)
    else $error("register write did not start the clearing pass");

endmodule
